// ----- src/pbs_pkg.sv -----
// Package for the priority batch scheduler: payload structs, result kinds,
// the request-table entry record and saturation constants. No dependencies.
`default_nettype none
package pbs_pkg;

  localparam int unsigned SAT_W = 26;
  localparam logic [SAT_W-1:0] SAT26 = {SAT_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic {
    REQ_SUBMIT   = 1'b0,
    REQ_DISPATCH = 1'b1
  } req_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  urgency;
    logic [31:0] deadline;
    logic [31:0] sub_time;
    logic [12:0] seq_len;
    logic [7:0]  seq_count;
    logic [31:0] req_id;
    logic [31:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        accepted;
    logic [31:0] dispatched_id;
    logic [7:0]  dispatched_urgency;
    logic        deadline_missed;
    logic [12:0] dispatched_length;
    logic [7:0]  dispatched_count;
    logic        final_of_batch;
    logic [25:0] batch_tokens;
    logic [12:0] batch_longest;
    logic [25:0] batch_padding;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  urgency;
    logic [31:0] deadline;
    logic [31:0] sub_time;
    logic [12:0] seq_len;
    logic [7:0]  seq_count;
    logic [31:0] req_id;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // true when a is served before b; ties go to the entry seen first
  function automatic logic goes_first(entry_t a, entry_t b);
    logic [32:0] da;
    logic [32:0] db;
    da = (a.deadline == 32'd0) ? {1'b1, 32'd0} : {1'b0, a.deadline};
    db = (b.deadline == 32'd0) ? {1'b1, 32'd0} : {1'b0, b.deadline};
    if (a.urgency != b.urgency) return a.urgency < b.urgency;
    if (da != db) return da < db;
    return a.sub_time < b.sub_time;
  endfunction

endpackage
`default_nettype wire

// ----- src/pbs_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/priority_batch_scheduler.sv -----
// Priority batch scheduler: request table held in one RAM, valid bits in flops,
// a scan sequencer that picks the best pending entry per dispatched result.
// Depends on pbs_pkg and pbs_ram.
//
// Use: one input channel (in_valid/in_ready, in_item) carries submit and
// dispatch transactions; one output channel (out_valid/out_ready, out_item)
// carries results. batch_size_we/batch_size_wdata write the batch limit.
// A submit finds the lowest free slot from the valid bits combinationally and
// writes the RAM: its result is valid the cycle after acceptance, and the
// next transaction is taken only once that result has been taken.
// A dispatch runs one scan of the table per result (one RAM read per cycle),
// so a batch of n entries takes n scans, plus the wait on the output
// register; an empty table gives a single empty result.
// One transaction is in work at a time; in_ready is high only when idle.
// When the receiver stalls, the result waits in the output register; the next
// scan still runs, and the emit step holds until the result is taken.
// Reset clears all valid bits and sets the batch limit to 64; the RAM holds
// no reset.
`default_nettype none
module priority_batch_scheduler #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned BATCH_CEIL  = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pbs_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pbs_pkg::out_item_t     out_item,
  input  wire logic              batch_size_we,
  input  wire logic [6:0]        batch_size_wdata
);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_EMIT = 5'b00100,
    ST_OUT  = 5'b01000,
    ST_ACK  = 5'b10000
  } state_t;

  state_t state;
  logic [TABLE_DEPTH-1:0] valid;
  logic [6:0] batch_size;
  logic [31:0] cur_time;
  logic [6:0] limit;
  logic [6:0] done_cnt;
  logic [CW-1:0] scan_idx;
  logic [AW-1:0] rd_idx;
  logic rd_live;
  logic have_best;
  logic [AW-1:0] best_idx;
  pbs_pkg::entry_t best;
  logic [31:0] tokens;
  logic [15:0] seqs;
  logic [12:0] longest;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  pbs_pkg::entry_t ram_wdata;
  pbs_pkg::entry_t ram_rdata;
  logic [AW-1:0] ram_raddr;

  logic free_found;
  logic [AW-1:0] free_idx;
  logic [6:0] limit_next;

  pbs_ram #(.WIDTH(pbs_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  always_comb begin
    limit_next = batch_size;
    if (batch_size == 7'd0) limit_next = 7'd1;
    if (batch_size > 7'(BATCH_CEIL)) limit_next = 7'(BATCH_CEIL);
  end

  assign in_ready  = (state == ST_IDLE) && !out_valid;
  assign ram_raddr = scan_idx[AW-1:0];
  assign ram_we    = in_valid && in_ready && (in_item.req_type == pbs_pkg::REQ_SUBMIT)
                     && free_found;
  assign ram_waddr = free_idx;
  assign ram_wdata = '{urgency: in_item.urgency, deadline: in_item.deadline,
                       sub_time: in_item.sub_time, seq_len: in_item.seq_len,
                       seq_count: in_item.seq_count, req_id: in_item.req_id};

  logic cand_better;
  assign cand_better = rd_live && valid[rd_idx] &&
                       (!have_best || pbs_pkg::goes_first(ram_rdata, best));

  logic [20:0] prod;
  logic [31:0] tok_sum;
  logic [15:0] seq_sum;
  logic [12:0] long_new;
  logic [28:0] long_x_seqs;
  logic [28:0] pad_full;
  logic [TABLE_DEPTH-1:0] best_mask;
  logic last;
  assign prod        = 21'(best.seq_len) * 21'(best.seq_count);
  assign tok_sum     = tokens + 32'(prod);
  assign seq_sum     = seqs + 16'(best.seq_count);
  assign long_new    = (best.seq_len > longest) ? best.seq_len : longest;
  assign long_x_seqs = 29'(long_new) * 29'(seq_sum);
  assign pad_full    = long_x_seqs - 29'(tok_sum);
  assign best_mask   = TABLE_DEPTH'(1) << best_idx;
  assign last        = (done_cnt + 7'd1 == limit) || ((valid & ~best_mask) == '0);

  pbs_pkg::out_item_t ack_item;
  pbs_pkg::out_item_t empty_item;
  pbs_pkg::out_item_t entry_item;

  always_comb begin
    ack_item = '0;
    ack_item.result_kind = pbs_pkg::KIND_ACK;
    ack_item.accepted = free_found;
    empty_item = '0;
    empty_item.result_kind = pbs_pkg::KIND_EMPTY;
    empty_item.final_of_batch = 1'b1;
    entry_item = '0;
    entry_item.result_kind = pbs_pkg::KIND_ENTRY;
    entry_item.dispatched_id = best.req_id;
    entry_item.dispatched_urgency = best.urgency;
    entry_item.deadline_missed = (best.deadline != 32'd0) && (cur_time > best.deadline);
    entry_item.dispatched_length = best.seq_len;
    entry_item.dispatched_count = best.seq_count;
    if (last) begin
      entry_item.final_of_batch = 1'b1;
      entry_item.batch_tokens = (tok_sum > 32'(pbs_pkg::SAT26)) ?
                                pbs_pkg::SAT26 : tok_sum[25:0];
      entry_item.batch_longest = long_new;
      entry_item.batch_padding = (pad_full > 29'(pbs_pkg::SAT26)) ?
                                 pbs_pkg::SAT26 : pad_full[25:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      batch_size <= 7'd64;
      out_valid <= 1'b0;
      rd_live <= 1'b0;
    end else begin
      if (batch_size_we) batch_size <= batch_size_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_item.req_type == pbs_pkg::REQ_SUBMIT) begin
              if (free_found) valid[free_idx] <= 1'b1;
              out_item <= ack_item;
              out_valid <= 1'b1;
            end else begin
              cur_time <= in_item.current_time;
              limit <= limit_next;
              done_cnt <= '0;
              tokens <= '0;
              seqs <= '0;
              longest <= '0;
              scan_idx <= '0;
              rd_live <= 1'b0;
              have_best <= 1'b0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_idx <= scan_idx[AW-1:0];
          rd_live <= (scan_idx < CW'(TABLE_DEPTH));
          if (scan_idx < CW'(TABLE_DEPTH)) scan_idx <= scan_idx + 1'b1;
          if (cand_better) begin
            best <= ram_rdata;
            best_idx <= rd_idx;
            have_best <= 1'b1;
          end
          if (scan_idx == CW'(TABLE_DEPTH) && !rd_live) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid) begin
            if (!have_best) begin
              if (done_cnt == 7'd0) begin
                out_item <= empty_item;
                out_valid <= 1'b1;
              end
              state <= ST_IDLE;
            end else begin
              valid[best_idx] <= 1'b0;
              out_item <= entry_item;
              out_valid <= 1'b1;
              tokens <= tok_sum;
              seqs <= seq_sum;
              longest <= long_new;
              done_cnt <= done_cnt + 7'd1;
              scan_idx <= '0;
              rd_live <= 1'b0;
              have_best <= 1'b0;
              state <= last ? ST_IDLE : ST_SCAN;
            end
          end
        end
        ST_OUT: state <= ST_IDLE;
        ST_ACK: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped under stall");
  a_submit_sets: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> valid[$past(ram_waddr)]) else $error("slot not marked");
  a_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> done_cnt < limit) else $error("batch overrun");
endmodule
`default_nettype wire

// ----- verif/priority_batch_scheduler_test.sv -----
// Testbench for priority_batch_scheduler: submit and dispatch transactions with a
// self-checking table predictor and a result queue. Depends on pbs_pkg and the RTL.
module priority_batch_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int BATCH_CAP = 64;
  localparam int HOLD_OFF_LEN = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pbs_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pbs_pkg::out_item_t out_item;
  logic batch_size_we = 1'b0;
  logic [6:0] batch_size_wdata = '0;

  priority_batch_scheduler u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .batch_size_we(batch_size_we), .batch_size_wdata(batch_size_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor state
  logic table_used [DEPTH];
  pbs_pkg::entry_t table_entry [DEPTH];
  logic [6:0] batch_limit;
  pbs_pkg::out_item_t expected_results[$];

  int mismatches = 0;
  int results_seen = 0;
  int entries_seen = 0;
  int refusals_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int hold_off_token = 0;
  int hold_off_seen = 0;

  function automatic void push_expected(pbs_pkg::out_item_t r);
    expected_results = {expected_results, r};
  endfunction

  function automatic logic serves_first(int a, int b);
    logic [32:0] da;
    logic [32:0] db;
    pbs_pkg::entry_t ea;
    pbs_pkg::entry_t eb;
    ea = table_entry[a];
    eb = table_entry[b];
    da = (ea.deadline == 32'd0) ? 33'h1_0000_0000 : {1'b0, ea.deadline};
    db = (eb.deadline == 32'd0) ? 33'h1_0000_0000 : {1'b0, eb.deadline};
    if (ea.urgency != eb.urgency) return ea.urgency < eb.urgency;
    if (da != db) return da < db;
    if (ea.sub_time != eb.sub_time) return ea.sub_time < eb.sub_time;
    return a < b;
  endfunction

  function automatic void predict_schedule(pbs_pkg::in_item_t it);
    pbs_pkg::out_item_t r;
    int free_slot;
    int best;
    int n;
    int lim;
    logic [63:0] tokens;
    logic [63:0] seqs;
    logic [63:0] pad;
    logic [12:0] longest;
    free_slot = -1;
    n = 0;
    tokens = '0;
    seqs = '0;
    longest = '0;
    r = '0;
    if (it.req_type == pbs_pkg::REQ_SUBMIT) begin
      for (int i = 0; i < DEPTH; i++)
        if (!table_used[i] && free_slot < 0) free_slot = i;
      r.result_kind = pbs_pkg::KIND_ACK;
      if (free_slot >= 0) begin
        table_used[free_slot] = 1'b1;
        table_entry[free_slot] = '{it.urgency, it.deadline, it.sub_time,
                                   it.seq_len, it.seq_count, it.req_id};
        r.accepted = 1'b1;
      end
      push_expected(r);
      return;
    end
    lim = (batch_limit == 7'd0) ? 1 : (int'(batch_limit) > BATCH_CAP ? BATCH_CAP
                                                                    : int'(batch_limit));
    while (n < lim) begin
      best = -1;
      for (int i = 0; i < DEPTH; i++)
        if (table_used[i] && (best < 0 || serves_first(i, best))) best = i;
      if (best < 0) break;
      table_used[best] = 1'b0;
      r = '0;
      r.result_kind = pbs_pkg::KIND_ENTRY;
      r.dispatched_id = table_entry[best].req_id;
      r.dispatched_urgency = table_entry[best].urgency;
      r.deadline_missed = table_entry[best].deadline != 32'd0 &&
                          it.current_time > table_entry[best].deadline;
      r.dispatched_length = table_entry[best].seq_len;
      r.dispatched_count = table_entry[best].seq_count;
      tokens += 64'(table_entry[best].seq_len) * 64'(table_entry[best].seq_count);
      seqs += 64'(table_entry[best].seq_count);
      if (table_entry[best].seq_len > longest) longest = table_entry[best].seq_len;
      push_expected(r);
      n++;
    end
    if (n == 0) begin
      r = '0;
      r.result_kind = pbs_pkg::KIND_EMPTY;
      r.final_of_batch = 1'b1;
      push_expected(r);
      return;
    end
    pad = 64'(longest) * seqs - tokens;
    r = expected_results.pop_back();
    r.final_of_batch = 1'b1;
    r.batch_tokens = (tokens > 64'(pbs_pkg::SAT26)) ? pbs_pkg::SAT26 : tokens[25:0];
    r.batch_longest = longest;
    r.batch_padding = (pad > 64'(pbs_pkg::SAT26)) ? pbs_pkg::SAT26 : pad[25:0];
    push_expected(r);
  endfunction

  // result checker
  always @(posedge clk) begin
    pbs_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = expected_results.pop_front();
        if (want.result_kind == pbs_pkg::KIND_ENTRY) entries_seen++;
        if (want.result_kind == pbs_pkg::KIND_ACK && !want.accepted) refusals_seen++;
        if (out_item !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, out_item);
        end
      end
    end
  end

  // receiver stalls, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_off_token != hold_off_seen) begin
      hold_off_seen <= hold_off_token;
      hold_off_cycles <= HOLD_OFF_LEN;
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(pbs_pkg::in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_schedule(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8 * DEPTH) @(posedge clk);
  endtask

  task automatic write_limit(logic [6:0] v);
    wait_drained();
    batch_size_we <= 1'b1;
    batch_size_wdata <= v;
    @(posedge clk);
    batch_size_we <= 1'b0;
    batch_limit = v;
  endtask

  function automatic pbs_pkg::in_item_t make_submit(logic [7:0] urg, logic [31:0] dl,
                                                    logic [31:0] st, logic [12:0] len,
                                                    logic [7:0] cnt);
    pbs_pkg::in_item_t it;
    it = '0;
    it.req_type = pbs_pkg::REQ_SUBMIT;
    it.urgency = urg;
    it.deadline = dl;
    it.sub_time = st;
    it.seq_len = len;
    it.seq_count = cnt;
    it.req_id = $urandom;
    it.current_time = $urandom;
    return it;
  endfunction

  function automatic pbs_pkg::in_item_t make_dispatch(logic [31:0] now);
    pbs_pkg::in_item_t it;
    it = '0;
    it.req_type = pbs_pkg::REQ_DISPATCH;
    it.current_time = now;
    it.urgency = 8'($urandom);
    it.deadline = $urandom;
    it.sub_time = $urandom;
    it.seq_len = 13'($urandom);
    it.seq_count = 8'($urandom);
    it.req_id = $urandom;
    return it;
  endfunction

  function automatic pbs_pkg::in_item_t random_submit();
    logic [31:0] dl;
    case ($urandom_range(3))
      0: dl = 32'd0;
      1: dl = 32'hFFFF_FFFF - $urandom_range(3);
      default: dl = $urandom_range(200);
    endcase
    return make_submit(8'($urandom_range(3) == 0 ? $urandom : $urandom_range(3)), dl,
                       $urandom_range(1) ? $urandom : $urandom_range(4),
                       13'($urandom_range(9) == 0 ? $urandom : $urandom_range(4096)),
                       8'($urandom));
  endfunction

  task automatic test_directed();
    send_item(make_dispatch(32'd0));
    send_item(make_submit(8'hFF, 32'd0, 32'hFFFF_FFFF, 13'd4096, 8'd255));
    send_item(make_submit(8'h00, 32'hFFFF_FFFF, 32'd0, 13'd0, 8'd0));
    send_item(make_submit(8'h00, 32'd5, 32'd7, 13'h1FFF, 8'd255));
    send_item(make_submit(8'h00, 32'd5, 32'd7, 13'd1, 8'd1));
    send_item(make_submit(8'h00, 32'd0, 32'd3, 13'd100, 8'd2));
    send_item(make_submit(8'h00, 32'd5, 32'd6, 13'd4096, 8'd255));
    send_item(make_dispatch(32'd6));
    send_item(make_dispatch(32'hFFFF_FFFF));
    send_item(make_dispatch(32'd0));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < DEPTH + 3; i++) send_item(random_submit());
    send_item(make_dispatch($urandom));
    send_item(make_dispatch($urandom));
  endtask

  task automatic test_limits();
    logic [6:0] limits [5] = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd3};
    foreach (limits[k]) begin
      write_limit(limits[k]);
      for (int i = 0; i < 6; i++) send_item(random_submit());
      send_item(make_dispatch($urandom_range(300)));
      send_item(make_dispatch($urandom));
    end
    write_limit(7'd64);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(4) == 0) send_item(make_dispatch($urandom_range(1) ? $urandom
                                                           : $urandom_range(300)));
      else send_item(random_submit());
    end
  endtask

  task automatic test_backpressure();
    hold_off_token++;
    for (int i = 0; i < 10; i++) send_item(random_submit());
    send_item(make_dispatch($urandom));
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) table_used[i] = 1'b0;
    batch_limit = 7'd64;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_limits();
    test_random(80);
    send_idle_pct = 54;
    test_random(80);
    write_limit(7'd8);
    send_idle_pct = 0;
    recv_stall_pct = 54;
    test_random(80);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    test_random(80);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    wait_drained();
    $display("covered submits, refusals (%0d), dispatches of %0d entries, limits 0..127",
             refusals_seen, entries_seen);
    $display("results checked: %0d, mismatches: %0d", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("priority_batch_scheduler_test passed");
    end else begin
      $display("priority_batch_scheduler_test failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("priority_batch_scheduler_test failed");
    $finish;
  end

endmodule
